// ----- hdl/sit_pkg.sv -----
// Shared types and constants of the sorted integer table.
// No dependencies; every other file of the block but sit_if imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sit_pkg;

  // Cells are grouped in lanes of this many for the scan and the readout.
  localparam int unsigned SIT_LANE   = 16;
  localparam int unsigned SIT_LANE_W = 4;

  typedef enum logic [1:0] {
    ACT_ADD,
    ACT_FIND,
    ACT_DETACH,
    ACT_READ
  } action_e;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_NOT_FOUND,
    STAT_FULL,
    STAT_RANGE
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CMP,
    ST_SEARCH,
    ST_SCAN,
    ST_FETCH,
    ST_PICK,
    ST_SHIFT,
    ST_DONE
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/sit_if.sv -----
// Channel interfaces of the sorted integer table: request, response and
// configuration, each with valid, ready and its payload. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface sit_req_if #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned VALUE_WIDTH = 32
) ();
  localparam int unsigned AW = $clog2(DEPTH);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    action;
  logic signed [VALUE_WIDTH-1:0] value;
  logic [AW-1:0]                 index;

  modport source (output valid, action, value, index, input ready);
  modport sink   (input valid, action, value, index, output ready);
endinterface

interface sit_rsp_if #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned VALUE_WIDTH = 32
) ();
  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [AW-1:0]                 position;
  logic signed [VALUE_WIDTH-1:0] entry_value;
  logic [CW-1:0]                 entry_count;

  modport source (output valid, status, position, entry_value, entry_count, input ready);
  modport sink   (input valid, status, position, entry_value, entry_count, output ready);
endinterface

interface sit_cfg_if ();
  logic valid;
  logic ready;
  logic sorted_mode;

  modport source (output valid, sorted_mode, input ready);
  modport sink   (input valid, sorted_mode, output ready);
endinterface

`default_nettype wire

// ----- hdl/sit_cell.sv -----
// One storage cell of the table chain: holds an entry, shifts it to or from
// its neighbours and compares it with the broadcast key. Uses sit_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sit_cell #(
  parameter int unsigned VALUE_WIDTH = 32,
  parameter int unsigned AW          = 8,
  parameter int unsigned CELL_IDX    = 0
) (
  input  wire logic                          clk_i,
  input  wire logic signed [VALUE_WIDTH-1:0] key_i,
  input  wire logic [AW-1:0]                 pos_i,
  input  wire sit_pkg::cell_op_e             op_i,
  input  wire logic signed [VALUE_WIDTH-1:0] left_i,
  input  wire logic signed [VALUE_WIDTH-1:0] right_i,
  output logic signed [VALUE_WIDTH-1:0]      value_o,
  output logic                               le_o,
  output logic                               eq_o
);
  import sit_pkg::*;

  logic signed [VALUE_WIDTH-1:0] value_q, value_d;
  logic                          le_q, ge_q;
  logic                          is_after, is_here;

  assign is_after = pos_i < AW'(CELL_IDX);
  assign is_here  = pos_i == AW'(CELL_IDX);

  always_comb begin
    value_d = value_q;
    unique case (op_i)
      CELL_INSERT: begin
        if (is_after) begin
          value_d = left_i;
        end else if (is_here) begin
          value_d = key_i;
        end
      end
      CELL_REMOVE: begin
        if (is_after || is_here) begin
          value_d = right_i;
        end
      end
      default: value_d = value_q;
    endcase
  end

  // The flags are registered and follow the key in the next cycle.
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    le_q    <= value_q <= key_i;
    ge_q    <= key_i <= value_q;
  end

  assign value_o = value_q;
  assign le_o    = le_q;
  assign eq_o    = le_q & ge_q;

endmodule

`default_nettype wire

// ----- hdl/sit_ctrl.sv -----
// Sequencer of the sorted integer table: handshakes, fill count, binary
// search, lane scan, two-level readout and shift commands. Uses sit_pkg, sit_if.
`timescale 1ns / 1ps
`default_nettype none

module sit_ctrl #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned VALUE_WIDTH = 32,
  localparam int unsigned AW   = $clog2(DEPTH),
  localparam int unsigned CW   = $clog2(DEPTH + 1),
  localparam int unsigned NGRP = (DEPTH + sit_pkg::SIT_LANE - 1) / sit_pkg::SIT_LANE,
  localparam int unsigned GW   = (NGRP > 1) ? $clog2(NGRP) : 1
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  sit_req_if.sink                               req_i,
  sit_rsp_if.source                             rsp_o,
  sit_cfg_if.sink                               cfg_i,
  input  wire logic [DEPTH-1:0]                 le_i,
  input  wire logic [NGRP-1:0][sit_pkg::SIT_LANE-1:0] eq_i,
  input  wire logic signed [VALUE_WIDTH-1:0]    val_i [NGRP][sit_pkg::SIT_LANE],
  output logic signed [VALUE_WIDTH-1:0]         key_o,
  output logic [AW-1:0]                         pos_o,
  output sit_pkg::cell_op_e                     op_o
);
  import sit_pkg::*;

  localparam int unsigned BW = GW + SIT_LANE_W;
  localparam int unsigned XW = BW + 1;

  state_e                        state_q, state_d;
  action_e                       act_q, act_d;
  status_e                       stat_q, stat_d;
  logic signed [VALUE_WIDTH-1:0] key_q, key_d;
  logic signed [VALUE_WIDTH-1:0] ev_q, ev_d;
  logic [AW-1:0]                 idx_q, idx_d;
  logic [AW-1:0]                 pos_q, pos_d;
  logic [CW-1:0]                 count_q, count_d;
  logic signed [CW:0]            lo_q, lo_d, hi_q, hi_d;
  logic [GW-1:0]                 chunk_q, chunk_d;
  logic                          sorted_q;
  logic signed [VALUE_WIDTH-1:0] grp_q [NGRP];

  logic                          rsp_valid_q, rsp_valid_d, rsp_load;
  status_e                       rsp_stat_q;
  logic [AW-1:0]                 rsp_pos_q;
  logic signed [VALUE_WIDTH-1:0] rsp_ev_q;
  logic [CW-1:0]                 rsp_cnt_q;

  logic [NGRP*SIT_LANE-1:0]      eq_flat;
  logic [CW:0]                   mid_sum;
  logic [AW-1:0]                 mid;
  logic [AW-1:0]                 lo_ix;
  logic                          lo_lt_cnt;
  logic [BW-1:0]                 idx_x;
  logic [SIT_LANE_W-1:0]         idx_lane;
  logic [GW-1:0]                 idx_grp;
  logic                          scan_hit;
  logic [SIT_LANE_W-1:0]         scan_lane;

  assign eq_flat   = eq_i;
  assign mid_sum   = $unsigned(lo_q) + $unsigned(hi_q);
  assign mid       = mid_sum[AW:1];
  assign lo_ix     = lo_q[AW-1:0];
  assign lo_lt_cnt = lo_q < $signed({1'b0, count_q});
  assign idx_x     = BW'(idx_q);
  assign idx_lane  = idx_x[SIT_LANE_W-1:0];
  assign idx_grp   = idx_x[BW-1:SIT_LANE_W];

  // Lowest matching lane of the current group, ignoring positions past the fill.
  always_comb begin
    scan_hit  = 1'b0;
    scan_lane = '0;
    for (int j = SIT_LANE - 1; j >= 0; j--) begin
      if (eq_i[chunk_q][j] && (XW'({chunk_q, SIT_LANE_W'(j)}) < XW'(count_q))) begin
        scan_hit  = 1'b1;
        scan_lane = SIT_LANE_W'(j);
      end
    end
  end

  always_comb begin
    state_d  = state_q;
    act_d    = act_q;
    stat_d   = stat_q;
    key_d    = key_q;
    ev_d     = ev_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    count_d  = count_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    chunk_d  = chunk_q;
    op_o     = CELL_HOLD;
    rsp_load = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          act_d   = action_e'(req_i.action);
          key_d   = req_i.value;
          idx_d   = req_i.index;
          stat_d  = STAT_OK;
          ev_d    = '0;
          pos_d   = '0;
          lo_d    = '0;
          hi_d    = $signed({1'b0, count_q}) - $signed((CW + 1)'(1));
          chunk_d = '0;
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        unique case (act_q)
          ACT_ADD: begin
            if (count_q == CW'(DEPTH)) begin
              stat_d  = STAT_FULL;
              state_d = ST_DONE;
            end else if (sorted_q) begin
              state_d = ST_SEARCH;
            end else begin
              pos_d   = AW'(count_q);
              state_d = ST_SHIFT;
            end
          end
          ACT_FIND: begin
            state_d = sorted_q ? ST_SEARCH : ST_SCAN;
          end
          default: begin
            pos_d = idx_q;
            if (CW'(idx_q) >= count_q) begin
              stat_d  = STAT_RANGE;
              state_d = ST_DONE;
            end else begin
              state_d = ST_FETCH;
            end
          end
        endcase
      end
      ST_SEARCH: begin
        if (act_q == ACT_ADD) begin
          // Upper-bound search; the last step steps over one more entry not above the key.
          if (lo_q < hi_q) begin
            if (le_i[mid]) begin
              lo_d = $signed((CW + 1)'(mid) + (CW + 1)'(1));
            end else begin
              hi_d = $signed((CW + 1)'(mid));
            end
          end else begin
            pos_d   = (lo_lt_cnt && le_i[lo_ix]) ? lo_ix + AW'(1) : lo_ix;
            state_d = ST_SHIFT;
          end
        end else begin
          if (lo_q <= hi_q) begin
            if (eq_flat[mid]) begin
              pos_d   = mid;
              state_d = ST_DONE;
            end else if (le_i[mid]) begin
              lo_d = $signed((CW + 1)'(mid) + (CW + 1)'(1));
            end else begin
              hi_d = $signed((CW + 1)'(mid)) - $signed((CW + 1)'(1));
            end
          end else begin
            stat_d  = STAT_NOT_FOUND;
            pos_d   = '0;
            state_d = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_hit) begin
          pos_d   = AW'({chunk_q, scan_lane});
          state_d = ST_DONE;
        end else if (chunk_q == GW'(NGRP - 1)) begin
          stat_d  = STAT_NOT_FOUND;
          pos_d   = '0;
          state_d = ST_DONE;
        end else begin
          chunk_d = chunk_q + GW'(1);
        end
      end
      ST_FETCH: begin
        state_d = ST_PICK;
      end
      ST_PICK: begin
        ev_d    = grp_q[idx_grp];
        state_d = (act_q == ACT_DETACH) ? ST_SHIFT : ST_DONE;
      end
      ST_SHIFT: begin
        if (act_q == ACT_ADD) begin
          op_o    = CELL_INSERT;
          count_d = count_q + CW'(1);
        end else begin
          op_o    = CELL_REMOVE;
          count_d = count_q - CW'(1);
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          rsp_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase

    if (rsp_load) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      sorted_q    <= 1'b1;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rsp_valid_q <= rsp_valid_d;
      if (cfg_i.valid) begin
        sorted_q <= cfg_i.sorted_mode;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    act_q   <= act_d;
    stat_q  <= stat_d;
    key_q   <= key_d;
    ev_q    <= ev_d;
    idx_q   <= idx_d;
    pos_q   <= pos_d;
    lo_q    <= lo_d;
    hi_q    <= hi_d;
    chunk_q <= chunk_d;
    // First readout level: one entry per lane group, picked by the low index bits.
    if (state_q == ST_FETCH) begin
      for (int g = 0; g < NGRP; g++) begin
        grp_q[g] <= val_i[g][idx_lane];
      end
    end
    if (rsp_load) begin
      rsp_stat_q <= stat_q;
      rsp_pos_q  <= pos_q;
      rsp_ev_q   <= ev_q;
      rsp_cnt_q  <= count_q;
    end
  end

  assign req_i.ready       = state_q == ST_IDLE;
  assign cfg_i.ready       = 1'b1;
  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.status      = rsp_stat_q;
  assign rsp_o.position    = rsp_pos_q;
  assign rsp_o.entry_value = rsp_ev_q;
  assign rsp_o.entry_count = rsp_cnt_q;
  assign key_o             = key_q;
  assign pos_o             = pos_q;

`ifndef ASSERT_OFF
  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(DEPTH))
    else $error("fill count exceeds table depth");

  a_insert_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == CELL_INSERT |-> count_q < CW'(DEPTH))
    else $error("insert issued into a full table");

  a_remove_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == CELL_REMOVE |-> CW'(pos_o) < count_q)
    else $error("remove issued past the filled entries");

  a_insert_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_o == CELL_INSERT |=> count_q == $past(count_q) + CW'(1))
    else $error("insert did not raise the fill count by one");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_stat_q == STAT_FULL |-> rsp_cnt_q == CW'(DEPTH))
    else $error("table full reported with room left");
`endif

endmodule

`default_nettype wire

// ----- hdl/sorted_integer_table.sv -----
// Top level of the sorted integer table: a chain of entry cells and the
// sequencer. Uses sit_pkg, sit_if, sit_cell and sit_ctrl.
`timescale 1ns / 1ps
`default_nettype none

// A table of up to DEPTH signed entries held in a chain of cells, kept in
// ascending order (sorted_mode 1, the reset value) or in arrival order. One
// request is in work at a time; a new request is taken once the previous one
// has moved its result into the output register, so a waiting result does
// not block the next request. An add passes a compare, in sorted mode the
// binary-search steps (at most log2(DEPTH) + 1), a shift and the output;
// a find passes a compare and the search steps, or in arrival order a scan
// of one group of 16 entries per step; a read passes a compare, a fetch and
// a pick, and a detach adds a shift. Adding to a full table or naming
// an index at or past the fill is answered right after the compare. All
// cells compare against the key in parallel; inserts and removals shift the
// whole chain at once; a read goes through two registered selection levels.
// Entries hold no reset value and need no clearing after reset. sorted_mode
// may be written at any time the block is idle and does not reorder the
// table.

module sorted_integer_table #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  sit_req_if.sink    req_i,
  sit_rsp_if.source  rsp_o,
  sit_cfg_if.sink    cfg_i
);
  import sit_pkg::*;

  localparam int unsigned AW   = $clog2(DEPTH);
  localparam int unsigned NGRP = (DEPTH + SIT_LANE - 1) / SIT_LANE;

  logic signed [VALUE_WIDTH-1:0] key;
  logic [AW-1:0]                 pos;
  cell_op_e                      op;
  logic signed [VALUE_WIDTH-1:0] cell_val [DEPTH];
  logic [DEPTH-1:0]              le_vec;
  logic [NGRP-1:0][SIT_LANE-1:0] eq_grp;
  logic signed [VALUE_WIDTH-1:0] val_grp [NGRP][SIT_LANE];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [VALUE_WIDTH-1:0] left, right;

    if (i == 0) begin : g_first
      assign left = key;
    end else begin : g_link_left
      assign left = cell_val[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_link_right
      assign right = cell_val[i+1];
    end

    sit_cell #(
      .VALUE_WIDTH (VALUE_WIDTH),
      .AW          (AW),
      .CELL_IDX    (i)
    ) u_cell (
      .clk_i   (clk_i),
      .key_i   (key),
      .pos_i   (pos),
      .op_i    (op),
      .left_i  (left),
      .right_i (right),
      .value_o (cell_val[i]),
      .le_o    (le_vec[i]),
      .eq_o    (eq_grp[i / SIT_LANE][i % SIT_LANE])
    );

    assign val_grp[i / SIT_LANE][i % SIT_LANE] = cell_val[i];
  end

  // Lanes of the last group beyond the table never match and read as zero.
  for (genvar p = DEPTH; p < NGRP * SIT_LANE; p++) begin : g_pad
    assign eq_grp[p / SIT_LANE][p % SIT_LANE]  = 1'b0;
    assign val_grp[p / SIT_LANE][p % SIT_LANE] = '0;
  end

  sit_ctrl #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cfg_i  (cfg_i),
    .le_i   (le_vec),
    .eq_i   (eq_grp),
    .val_i  (val_grp),
    .key_o  (key),
    .pos_o  (pos),
    .op_o   (op)
  );

endmodule

`default_nettype wire

// ----- test/sit_table_checker.sv -----
// Checker for the sorted integer table: watches the request, response and
// configuration channels, predicts each result and compares it on arrival.
// Depends on sit_pkg and the channel interfaces in sit_if.
`timescale 1ns / 1ps

module sit_table_checker #(
  parameter int unsigned DEPTH       = 256,
  parameter int unsigned VALUE_WIDTH = 32
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  sit_req_if          req_mon,
  sit_rsp_if          rsp_mon,
  sit_cfg_if          cfg_mon,
  output int unsigned errors_o,
  output int unsigned pending_o,
  output int unsigned fill_o,
  output int unsigned checked_o
);
  import sit_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  typedef logic signed [VALUE_WIDTH-1:0] word_t;

  typedef struct packed {
    status_e       status;
    logic [AW-1:0] position;
    word_t         entry_value;
    logic [CW-1:0] entry_count;
  } table_result_t;

  word_t         cells [DEPTH];
  int unsigned   held;
  logic          sorted_q;
  table_result_t awaited_results [$];
  int unsigned   errors;
  int unsigned   checked;

  // Applies one request to the shadow table and returns what the block must answer.
  task automatic apply_table_op(input action_e act, input word_t v,
                                input logic [AW-1:0] idx, output table_result_t res);
    int lo;
    int hi;
    int mid;
    int n;
    bit hit;
    res.status      = STAT_OK;
    res.position    = '0;
    res.entry_value = '0;
    n   = int'(held);
    hit = 1'b0;
    case (act)
      ACT_ADD: begin
        if (held >= DEPTH) begin
          res.status = STAT_FULL;
        end else begin
          if (sorted_q) begin
            // Land after any equal entries; the search runs on whatever order is held.
            lo = 0;
            hi = n - 1;
            while (lo < hi) begin
              mid = (lo + hi) / 2;
              if (cells[mid] <= v) lo = mid + 1;
              else hi = mid;
            end
            if (lo < n && cells[lo] <= v) lo++;
          end else begin
            lo = n;
          end
          for (int i = n; i > lo; i--) cells[i] = cells[i-1];
          cells[lo]    = v;
          held++;
          res.position = AW'(lo);
        end
      end
      ACT_FIND: begin
        if (sorted_q) begin
          lo = 0;
          hi = n - 1;
          while (lo <= hi && !hit) begin
            mid = (lo + hi) / 2;
            if (cells[mid] <= v) begin
              if (v <= cells[mid]) begin
                hit          = 1'b1;
                res.position = AW'(mid);
              end else begin
                lo = mid + 1;
              end
            end else begin
              hi = mid - 1;
            end
          end
        end else begin
          for (int i = 0; i < n && !hit; i++) begin
            if (cells[i] == v) begin
              hit          = 1'b1;
              res.position = AW'(i);
            end
          end
        end
        if (!hit) res.status = STAT_NOT_FOUND;
      end
      default: begin
        res.position = idx;
        if (idx >= held) begin
          res.status = STAT_RANGE;
        end else begin
          res.entry_value = cells[idx];
          if (act == ACT_DETACH) begin
            for (int i = int'(idx); i + 1 < n; i++) cells[i] = cells[i+1];
            held--;
          end
        end
      end
    endcase
    res.entry_count = CW'(held);
  endtask

  task automatic compare_field(input string name, input logic signed [63:0] want,
                               input logic signed [63:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    table_result_t want;
    table_result_t predicted;
    if (!rst_ni) begin
      held     = 0;
      sorted_q = 1'b1;
      errors   = 0;
      checked  = 0;
      awaited_results.delete();
      errors_o  <= 0;
      pending_o <= 0;
      fill_o    <= 0;
      checked_o <= 0;
    end else begin
      if (rsp_mon.valid && rsp_mon.ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no request waiting, expected none, actual status %0d",
                   $time, rsp_mon.status);
          errors++;
        end else begin
          want = awaited_results.pop_front();
          checked++;
          compare_field("status", 64'(want.status), 64'(rsp_mon.status));
          compare_field("position", 64'(want.position), 64'(rsp_mon.position));
          compare_field("entry_value", 64'(want.entry_value), 64'(rsp_mon.entry_value));
          compare_field("entry_count", 64'(want.entry_count), 64'(rsp_mon.entry_count));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) sorted_q = cfg_mon.sorted_mode;
      if (req_mon.valid && req_mon.ready) begin
        apply_table_op(action_e'(req_mon.action), req_mon.value, req_mon.index, predicted);
        awaited_results.push_back(predicted);
      end
      errors_o  <= errors;
      pending_o <= awaited_results.size();
      fill_o    <= held;
      checked_o <= checked;
    end
  end

endmodule

// ----- test/sorted_integer_table_tb.sv -----
// Top of the sorted integer table testbench: clock, reset, stimulus, receiver
// stalls, watchdog and verdict. Uses sit_pkg, sit_if, the block and sit_table_checker.
`timescale 1ns / 1ps

module sorted_integer_table_tb;
  import sit_pkg::*;

  localparam int unsigned DEPTH       = 256;
  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned AW          = $clog2(DEPTH);
  // The longest quiet stretch of a correct run is the long receiver stall.
  localparam int unsigned LONG_STALL     = 300;
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned DRAIN_CYCLES   = 30;

  typedef logic signed [VALUE_WIDTH-1:0] word_t;

  localparam word_t INT_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam word_t INT_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic        clk;
  logic        rst_n;
  int unsigned errors;
  int unsigned pending;
  int unsigned fill;
  int unsigned checked;
  int unsigned sent;
  bit          no_idle;
  bit          long_stall_req;
  word_t       recent_values [$];

  sit_req_if #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) req_ch ();
  sit_rsp_if #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) rsp_ch ();
  sit_cfg_if cfg_ch ();

  sorted_integer_table #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch),
    .cfg_i  (cfg_ch)
  );

  sit_table_checker #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_checker (
    .clk_i     (clk),
    .rst_ni    (rst_n),
    .req_mon   (req_ch),
    .rsp_mon   (rsp_ch),
    .cfg_mon   (cfg_ch),
    .errors_o  (errors),
    .pending_o (pending),
    .fill_o    (fill),
    .checked_o (checked)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic send_request(input action_e act, input word_t v, input logic [AW-1:0] idx);
    if (!no_idle && $urandom_range(0, 99) < 25) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid  <= 1'b1;
    req_ch.action <= act;
    req_ch.value  <= v;
    req_ch.index  <= idx;
    do @(posedge clk); while (!req_ch.ready);
    sent++;
    if (act == ACT_ADD) begin
      recent_values.push_back(v);
      if (recent_values.size() > 16) void'(recent_values.pop_front());
    end
  endtask

  // The checker's counts are registered, hence the clock edge before looking.
  task automatic wait_idle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic write_mode(input bit mode);
    wait_idle();
    repeat (4) @(posedge clk);
    cfg_ch.valid       <= 1'b1;
    cfg_ch.sorted_mode <= mode;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // Small values give duplicates and hits; recent adds make full-range finds hit.
  function automatic word_t pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 4) return word_t'(int'($urandom_range(0, 16)) - 8);
    if (sel < 7) return word_t'($urandom);
    if (sel == 7) return INT_MIN + word_t'($urandom_range(0, 3));
    if (sel == 8) return INT_MAX - word_t'($urandom_range(0, 3));
    if (recent_values.size() > 0)
      return recent_values[$urandom_range(0, recent_values.size() - 1)];
    return word_t'($urandom);
  endfunction

  function automatic logic [AW-1:0] pick_index();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 8 && fill > 0) return AW'($urandom_range(0, fill - 1));
    if (sel < 9) return AW'(fill + $urandom_range(0, 2));
    return AW'($urandom);
  endfunction

  task automatic send_mixed(input int count, input int add_pct, input int find_pct,
                            input int detach_pct);
    int roll;
    repeat (count) begin
      roll = $urandom_range(0, 99);
      if (roll < add_pct)
        send_request(ACT_ADD, pick_value(), AW'($urandom));
      else if (roll < add_pct + find_pct)
        send_request(ACT_FIND, pick_value(), AW'($urandom));
      else if (roll < add_pct + find_pct + detach_pct)
        send_request(ACT_DETACH, word_t'($urandom), pick_index());
      else
        send_request(ACT_READ, word_t'($urandom), pick_index());
    end
  endtask

  // Receiver: random stalls, one long hold-off on request, none in the last part.
  initial begin
    bit long_stall_done;
    long_stall_done = 1'b0;
    rsp_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (long_stall_req && !long_stall_done) begin
        rsp_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(posedge clk);
        long_stall_done = 1'b1;
      end else if (!no_idle && $urandom_range(0, 99) < 30) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
      end else begin
        rsp_ch.ready <= 1'b1;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
        $display("[sorted_integer_table] ERROR");
        $finish;
      end
    end
  end

  initial begin
    rst_n              <= 1'b0;
    req_ch.valid       <= 1'b0;
    req_ch.action      <= ACT_ADD;
    req_ch.value       <= '0;
    req_ch.index       <= '0;
    cfg_ch.valid       <= 1'b0;
    cfg_ch.sorted_mode <= 1'b1;
    no_idle        = 1'b0;
    long_stall_req = 1'b0;
    sent           = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty table, extremes, duplicates, misses and bad indexes in sorted order.
    send_request(ACT_READ, '0, '0);
    send_request(ACT_DETACH, '0, '0);
    send_request(ACT_FIND, '0, '0);
    send_request(ACT_ADD, INT_MAX, '0);
    send_request(ACT_ADD, INT_MIN, '0);
    send_request(ACT_ADD, '0, '0);
    send_request(ACT_ADD, '0, '0);
    send_request(ACT_ADD, word_t'(-1), '0);
    send_request(ACT_FIND, '0, '0);
    send_request(ACT_FIND, INT_MIN, '0);
    send_request(ACT_FIND, INT_MAX, '0);
    send_request(ACT_FIND, word_t'(7), '0);
    send_request(ACT_READ, '0, AW'(0));
    send_request(ACT_READ, '0, AW'(4));
    send_request(ACT_READ, '0, AW'(5));
    send_request(ACT_DETACH, '0, {AW{1'b1}});
    send_request(ACT_DETACH, '0, AW'(2));
    send_request(ACT_READ, '0, AW'(2));
    // Arrival order on top of a sorted table, then sorted searches on an unsorted one.
    write_mode(1'b0);
    send_request(ACT_ADD, word_t'(5), '0);
    send_request(ACT_ADD, INT_MIN, '0);
    send_request(ACT_FIND, INT_MIN, '0);
    send_request(ACT_FIND, word_t'(5), '0);
    write_mode(1'b1);
    send_request(ACT_FIND, word_t'(5), '0);
    send_request(ACT_ADD, word_t'(3), '0);
    send_request(ACT_FIND, INT_MIN, '0);

    long_stall_req = 1'b1;
    send_mixed(120, 40, 30, 15);
    wait_idle();
    send_mixed(100, 40, 30, 15);

    write_mode(1'b0);
    send_mixed(200, 40, 30, 15);

    // Fill the table to the brim in sorted order, then probe it full.
    write_mode(1'b1);
    while (fill < DEPTH) send_request(ACT_ADD, pick_value(), AW'($urandom));
    repeat (3) send_request(ACT_ADD, pick_value(), AW'($urandom));
    send_request(ACT_READ, '0, {AW{1'b1}});
    send_request(ACT_READ, '0, '0);
    send_request(ACT_FIND, INT_MAX, '0);
    send_request(ACT_FIND, pick_value(), '0);
    write_mode(1'b0);
    send_request(ACT_ADD, pick_value(), '0);
    send_request(ACT_FIND, word_t'($urandom), '0);
    send_request(ACT_FIND, pick_value(), '0);
    send_mixed(150, 10, 20, 60);

    no_idle = 1'b1;
    write_mode(1'b1);
    send_mixed(100, 35, 30, 20);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests, checked %0d results across sorted and arrival order,",
             sent, checked);
    $display("mode changes on held tables, a full table and out-of-range indexes.");
    if (errors == 0 && pending == 0)
      $display("[sorted_integer_table] OK");
    else
      $display("[sorted_integer_table] ERROR");
    $finish;
  end

endmodule

// ----- sorted_integer_table.f -----
hdl/sit_pkg.sv
hdl/sit_if.sv
hdl/sit_cell.sv
hdl/sit_ctrl.sv
hdl/sorted_integer_table.sv
test/sit_table_checker.sv
test/sorted_integer_table_tb.sv
